FILE: rtl/bpa_pkg.sv
package bpa_pkg;

    // Fixed field widths of the request and result items and of the register bus.
    localparam int ADDR_W         = 48;
    localparam int COUNT_W        = 11;
    localparam int POOL_W         = 11;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 64;

    // Defaults for the top-level parameters.
    localparam int PAGES_DEF      = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] BASE_RESET = '0;
    localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } bpa_func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } bpa_status_t;

    // Register index, taken from paddr[3] (registers sit at 8-byte strides).
    typedef enum logic {
        REG_BASE = 1'b0,
        REG_POOL = 1'b1
    } bpa_reg_t;

    typedef struct packed {
        bpa_func_t           func;
        logic [COUNT_W-1:0]  page_count;
        logic [ADDR_W-1:0]   address;
    } bpa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   page_address;
        bpa_status_t         status;
    } bpa_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_INIT,
        S_A_SCAN,
        S_A_START,
        S_A_MARK_RD,
        S_A_MARK_WR,
        S_F_DIFF,
        S_F_CHECK,
        S_F_WRITE,
        S_RESP
    } bpa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_init;
        logic scan_step;
        logic calc_start;
        logic mark_rd;
        logic mark_wr;
        logic free_diff;
        logic free_check;
        logic free_wr;
        logic set_nospace;
    } bpa_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic row_last;
        logic early_fail;
        logic hit;
        logic exhausted;
        logic mark_last;
        logic free_ok;
    } bpa_stat_t;

endpackage

FILE: rtl/bpa_regs.sv
module bpa_regs
    import bpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output logic [ADDR_W-1:0]   base_address,
    output logic [POOL_W-1:0]   pool_pages
);

    logic [ADDR_W-1:0] base_reg;
    logic [POOL_W-1:0] pool_reg;
    logic              wr_en;
    bpa_reg_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign sel    = bpa_reg_t'(paddr[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            pool_reg <= POOL_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_BASE: base_reg <= pwdata[ADDR_W-1:0];
                REG_POOL: pool_reg <= pwdata[POOL_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_BASE: prdata = PDATA_W'(base_reg);
            REG_POOL: prdata = PDATA_W'(pool_reg);
            default:  prdata = '0;
        endcase
    end

    assign base_address = base_reg;
    assign pool_pages   = pool_reg;

endmodule

FILE: rtl/bpa_ctrl.sv
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  bpa_func_t  func,
    input  bpa_stat_t  stat,
    output bpa_cmd_t   cmd,
    output logic       busy,
    output logic       done
);

    bpa_state_t state_reg;
    bpa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (func == FN_FREE) ? S_F_DIFF : S_A_INIT;
                end
            end
            S_A_INIT:
            begin
                cmd.scan_init = 1'b1;
                if (stat.early_fail)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_A_SCAN;
                end
            end
            S_A_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_A_START;
                end
                else if (stat.exhausted)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = S_RESP;
                end
            end
            S_A_START:
            begin
                cmd.calc_start = 1'b1;
                state_next     = S_A_MARK_RD;
            end
            S_A_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = S_A_MARK_WR;
            end
            S_A_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                if (stat.mark_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_F_DIFF:
            begin
                cmd.free_diff = 1'b1;
                state_next    = S_F_CHECK;
            end
            S_F_CHECK:
            begin
                cmd.free_check = 1'b1;
                state_next     = stat.free_ok ? S_F_WRITE : S_RESP;
            end
            S_F_WRITE:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/bpa_datapath.sv
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int PAGES      = PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bpa_in_t            item,
    input  logic [ADDR_W-1:0]  base_address,
    input  logic [POOL_W-1:0]  pool_pages,
    input  bpa_cmd_t           cmd,
    output bpa_stat_t          stat,
    output bpa_out_t           result
);

    localparam int WORD   = (PAGES >= 32) ? 32 : 8;
    localparam int LANE_W = $clog2(WORD);
    localparam int ROWS   = (PAGES + WORD - 1) / WORD;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_W + LANE_W;
    localparam int LIM_W  = $clog2(PAGES + 1);
    localparam int CNT_W  = ((LIM_W > COUNT_W) ? LIM_W : COUNT_W) + 1;
    localparam int RUN_W  = LANE_W + 1;
    localparam int PIDX_W = ADDR_W - PAGE_SHIFT;

    // Page bitmap, one row of WORD pages per entry; a set bit means taken.
    logic [WORD-1:0]   mem [0:ROWS-1];
    logic [WORD-1:0]   rdata_reg;
    logic [ROW_W-1:0]  rd_addr;
    logic              we;
    logic [ROW_W-1:0]  waddr;
    logic [WORD-1:0]   wdata;

    logic [COUNT_W-1:0] len_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [ROW_W-1:0]   end_row_reg;
    logic [LANE_W-1:0]  end_lane_reg;
    logic [WORD-1:0]    hit_word_reg;
    logic [IDX_W-1:0]   start_reg;
    logic [ROW_W-1:0]   mark_row_reg;
    logic [ADDR_W-1:0]  diff_reg;
    logic               borrow_reg;
    logic [ROW_W-1:0]   free_row_reg;
    logic [LANE_W-1:0]  free_lane_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    bpa_status_t        res_status_reg;

    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   len_ext;
    logic [CNT_W-1:0]   base_idx;
    logic [CNT_W-1:0]   rem;
    logic [WORD-1:0]    free_vec;
    logic [RUN_W-1:0]   runs [0:LANE_W][0:WORD-1];
    logic [WORD-1:0]    from0_vec;
    logic [WORD-1:0]    hit_vec;
    logic [CNT_W-1:0]   tot;
    logic [LANE_W-1:0]  hit_lane;
    logic [CNT_W-1:0]   run_next;
    logic [ROW_W-1:0]   row_inc;
    logic [ROW_W-1:0]   start_row;
    logic [LANE_W-1:0]  start_lane;
    logic [LANE_W-1:0]  lo;
    logic [LANE_W-1:0]  hi;
    logic [WORD-1:0]    mark_mask;
    logic [WORD-1:0]    mark_old;
    logic [PIDX_W-1:0]  page_idx;
    logic [IDX_W-1:0]   free_idx;
    logic               free_ok;

    // Pages actually searched: the pool size, capped at the bitmap size.
    always_comb
    begin
        if (CNT_W'(pool_pages) > CNT_W'(PAGES))
        begin
            limit = CNT_W'(PAGES);
        end
        else
        begin
            limit = CNT_W'(pool_pages);
        end
    end

    assign len_ext  = CNT_W'(len_reg);
    assign base_idx = CNT_W'({row_reg, {LANE_W{1'b0}}});
    assign rem      = limit - base_idx;
    assign row_inc  = (row_reg == ROW_W'(ROWS - 1)) ? row_reg : row_reg + ROW_W'(1);

    // Free lanes of the current row; lanes past the pool count as taken.
    always_comb
    begin
        for (int l = 0; l < WORD; l++)
        begin
            free_vec[l] = ~rdata_reg[l] & (CNT_W'(l) < rem);
        end
    end

    // Length of the free run ending at each lane, by prefix doubling.
    always_comb
    begin
        for (int l = 0; l < WORD; l++)
        begin
            runs[0][l] = RUN_W'(free_vec[l]);
        end
        for (int s = 0; s < LANE_W; s++)
        begin
            for (int l = 0; l < WORD; l++)
            begin
                runs[s+1][l] = runs[s][l];
                if (l >= (1 << s))
                begin
                    if (runs[s][l] == RUN_W'(1 << s))
                    begin
                        runs[s+1][l] = RUN_W'(1 << s) + runs[s][l - (1 << s)];
                    end
                end
            end
        end
    end

    // A lane whose run reaches back to lane 0 extends the run carried in.
    always_comb
    begin
        tot       = '0;
        from0_vec = '0;
        hit_vec   = '0;
        hit_lane  = '0;
        for (int l = 0; l < WORD; l++)
        begin
            from0_vec[l] = (runs[LANE_W][l] == RUN_W'(l + 1));
            if (from0_vec[l])
            begin
                tot = run_reg + CNT_W'(l + 1);
            end
            else
            begin
                tot = CNT_W'(runs[LANE_W][l]);
            end
            hit_vec[l] = (tot >= len_ext);
        end
        for (int l = WORD - 1; l >= 0; l--)
        begin
            if (hit_vec[l])
            begin
                hit_lane = LANE_W'(l);
            end
        end
    end

    assign run_next = from0_vec[WORD-1] ? run_reg + CNT_W'(WORD)
                                        : CNT_W'(runs[LANE_W][WORD-1]);

    assign start_row  = start_reg[IDX_W-1:LANE_W];
    assign start_lane = start_reg[LANE_W-1:0];

    // Bits of the marked run that fall in the row being written.
    always_comb
    begin
        lo = (mark_row_reg == start_row) ? start_lane : '0;
        hi = (mark_row_reg == end_row_reg) ? end_lane_reg : LANE_W'(WORD - 1);
        for (int l = 0; l < WORD; l++)
        begin
            mark_mask[l] = (LANE_W'(l) >= lo) && (LANE_W'(l) <= hi);
        end
        // Rows strictly inside the run are entirely free.
        if (mark_row_reg == start_row)
        begin
            mark_old = rdata_reg;
        end
        else if (mark_row_reg == end_row_reg)
        begin
            mark_old = hit_word_reg;
        end
        else
        begin
            mark_old = '0;
        end
    end

    assign page_idx = diff_reg[ADDR_W-1:PAGE_SHIFT];
    assign free_idx = page_idx[IDX_W-1:0];
    assign free_ok  = !borrow_reg && (page_idx < PIDX_W'(limit));

    // Memory port selection.
    always_comb
    begin
        rd_addr = row_reg;
        we      = 1'b0;
        waddr   = row_reg;
        wdata   = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        if (cmd.scan_init)
        begin
            rd_addr = '0;
        end
        if (cmd.scan_step)
        begin
            rd_addr = row_inc;
        end
        if (cmd.mark_rd)
        begin
            rd_addr = start_row;
        end
        if (cmd.mark_wr)
        begin
            we    = 1'b1;
            waddr = mark_row_reg;
            wdata = mark_old | mark_mask;
        end
        if (cmd.free_check)
        begin
            rd_addr = free_idx[IDX_W-1:LANE_W];
        end
        if (cmd.free_wr)
        begin
            we    = 1'b1;
            waddr = free_row_reg;
            wdata = rdata_reg & ~(WORD'(1) << free_lane_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (cmd.clr_step || cmd.scan_step)
        begin
            row_reg <= row_reg + ROW_W'(1);
        end
        else if (cmd.scan_init)
        begin
            row_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg  <= item.page_count;
            addr_reg <= item.address;
        end
        if (cmd.scan_init)
        begin
            run_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            run_reg      <= run_next;
            end_row_reg  <= row_reg;
            end_lane_reg <= hit_lane;
            hit_word_reg <= rdata_reg;
        end
        if (cmd.calc_start)
        begin
            start_reg <= IDX_W'(CNT_W'({end_row_reg, end_lane_reg}) + CNT_W'(1) - len_ext);
        end
        if (cmd.mark_rd)
        begin
            mark_row_reg   <= start_row;
            res_addr_reg   <= base_address + (ADDR_W'(start_reg) << PAGE_SHIFT);
            res_status_reg <= ST_OK;
        end
        if (cmd.mark_wr)
        begin
            mark_row_reg <= mark_row_reg + ROW_W'(1);
        end
        if (cmd.free_diff)
        begin
            {borrow_reg, diff_reg} <= {1'b0, addr_reg} - {1'b0, base_address};
        end
        if (cmd.free_check)
        begin
            free_row_reg   <= free_idx[IDX_W-1:LANE_W];
            free_lane_reg  <= free_idx[LANE_W-1:0];
            res_addr_reg   <= '0;
            res_status_reg <= free_ok ? ST_OK : ST_RANGE;
        end
        if (cmd.set_nospace)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_NOSPACE;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.row_last   = (row_reg == ROW_W'(ROWS - 1));
        stat.early_fail = (len_reg == '0) || (len_ext > limit);
        stat.hit        = |hit_vec;
        stat.exhausted  = (base_idx + CNT_W'(WORD)) >= limit;
        stat.mark_last  = (mark_row_reg == end_row_reg);
        stat.free_ok    = free_ok;
    end

    assign result.page_address = res_addr_reg;
    assign result.status       = res_status_reg;

endmodule

FILE: rtl/bitmap_page_allocator_top.sv
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+-------------------------------------
// request   | start, busy (taken: start & !busy)| item   (func, page_count, address)
// result    | done (one-cycle strobe)           | result (page_address, status)
// config    | psel/penable/pwrite/pready        | paddr, pwdata, prdata
//
// After reset the bitmap is cleared one row (32 pages, 8 if PAGES < 32) per cycle
// with busy held high; configuration writes are taken meanwhile. An allocate scans
// the rows until a run is found, derives its first page, reads the first row and
// writes each row the run spans; one that finds no run stops at the pool's end, and
// a zero-length or oversized one is refused before any scan. A free checks the page
// against the pool and clears its bit if it lies inside. The receiver cannot stall.
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int PAGES      = PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  bpa_in_t             item,
    output logic                done,
    output bpa_out_t            result
);

    // Configuration registers: base address of the pool and number of pages in the pool.
    logic [ADDR_W-1:0] base_address;
    logic [POOL_W-1:0] pool_pages;

    // Command and status groups between the controller and the datapath.
    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .base_address (base_address),
        .pool_pages   (pool_pages)
    );

    // The controller sequences clearing, scanning, marking and freeing; it
    // sees the request's operation code at the cycle the item is accepted.
    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (item.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the bitmap memory, the run search and the address
    // arithmetic; it latches the item when told to load it.
    bpa_datapath #(
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .base_address (base_address),
        .pool_pages   (pool_pages),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result)
    );

endmodule

FILE: tb/page_map_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the page allocator,
// keeps its own copy of the page bitmap and registers, and compares every
// result with the answer owed to the oldest accepted request.
module page_map_checker
    import bpa_pkg::*;
#(
    parameter int PAGES      = PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,
    input  logic                start,
    input  logic                busy,
    input  bpa_in_t             item,
    input  logic                done,
    input  bpa_out_t            result,
    output int                  errors,
    output int                  pending
);

    logic [PAGES-1:0]   taken_pages;
    logic [ADDR_W-1:0]  pool_base;
    logic [POOL_W-1:0]  pool_len;
    bpa_out_t           owed_answers[$];
    int                 mismatches;

    // Lowest first page of a run of len free pages below limit, or -1.
    function automatic int lowest_free_run(int len, int limit);
        int run;
        run = 0;
        if (len == 0 || len > limit)
            return -1;
        for (int i = 0; i < limit; i++)
        begin
            if (taken_pages[i])
                run = 0;
            else
            begin
                run++;
                if (run == len)
                    return i + 1 - len;
            end
        end
        return -1;
    endfunction

    // Applies one request to the bitmap and returns the answer it is owed.
    function automatic bpa_out_t grant_or_release(bpa_in_t req);
        bpa_out_t           answer;
        int                 limit;
        int                 first;
        logic [ADDR_W-1:0]  index;
        answer.page_address = '0;
        answer.status       = ST_OK;
        limit = (pool_len > PAGES) ? PAGES : int'(pool_len);
        if (req.func == FN_ALLOC)
        begin
            first = lowest_free_run(int'(req.page_count), limit);
            if (first < 0)
                answer.status = ST_NOSPACE;
            else
            begin
                for (int k = 0; k < int'(req.page_count); k++)
                    taken_pages[first + k] = 1'b1;
                answer.page_address = pool_base + (ADDR_W'(first) << PAGE_SHIFT);
            end
        end
        else if (req.address < pool_base)
            answer.status = ST_RANGE;
        else
        begin
            index = (req.address - pool_base) >> PAGE_SHIFT;
            if (index >= ADDR_W'(limit))
                answer.status = ST_RANGE;
            else
                taken_pages[index] = 1'b0;
        end
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bpa_out_t           want;
        logic [PDATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            taken_pages = '0;
            pool_base   = BASE_RESET;
            pool_len    = POOL_RESET;
            owed_answers.delete();
            mismatches  = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            // A result leaving in the same cycle as a new acceptance belongs
            // to the earlier request, so results are matched first.
            if (done)
            begin
                if (owed_answers.size() == 0)
                begin
                    $error("unexpected result: page_address=%h status=%0d",
                           result.page_address, result.status);
                    mismatches++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (result.page_address !== want.page_address)
                    begin
                        $error("page_address: expected %h, got %h",
                               want.page_address, result.page_address);
                        mismatches++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                owed_answers.push_back(grant_or_release(item));
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (bpa_reg_t'(paddr[3]))
                        REG_BASE: pool_base = pwdata[ADDR_W-1:0];
                        REG_POOL: pool_len  = pwdata[POOL_W-1:0];
                    endcase
                end
                else
                begin
                    reg_value = (bpa_reg_t'(paddr[3]) == REG_BASE) ?
                                PDATA_W'(pool_base) : PDATA_W'(pool_len);
                    if (prdata !== reg_value)
                    begin
                        $error("prdata: expected %h, got %h", reg_value, prdata);
                        mismatches++;
                    end
                end
            end
            errors  <= mismatches;
            pending <= owed_answers.size();
        end
    end

endmodule

FILE: tb/tb_bitmap_page_allocator_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the bitmap page allocator. The checker beside the
// block predicts and compares every result; this module only drives requests
// and register accesses and decides pass or fail at the end of the run.
module tb_bitmap_page_allocator_top
    import bpa_pkg::*;
();

    // An allocate can read every bitmap row and then mark every row the run
    // spans, and the sender may pause between items. The limit lies well above
    // that longest quiet stretch and still ends a hung run quickly.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 80;
    localparam int PAGE_BYTES     = 1 << PAGE_SHIFT_DEF;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start;
    logic               busy;
    bpa_in_t            item;
    logic               done;
    bpa_out_t           result;
    int                 errors;
    int                 pending;

    // Cycles since anything last moved on any channel.
    int                 quiet_cycles = 0;
    // Chance in percent that the sender pauses after an item.
    int                 gap_pct;
    // The register values last written, used to aim free requests at the pool.
    logic [ADDR_W-1:0]  base_now;
    logic [POOL_W-1:0]  pool_now;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bitmap_page_allocator_top #(
        .PAGES      (PAGES_DEF),
        .PAGE_SHIFT (PAGE_SHIFT_DEF)
    ) dut (.*);

    page_map_checker #(
        .PAGES      (PAGES_DEF),
        .PAGE_SHIFT (PAGE_SHIFT_DEF)
    ) checker_inst (.*);

    // The watchdog restarts its count on every request taken, every result
    // and every register transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL bitmap_page_allocator_top");
        $finish;
    end

    // Address of a page of the pool as the registers stand now, plus an offset.
    function automatic logic [ADDR_W-1:0] page_at(int index, int offset);
        return base_now + ADDR_W'(index) * ADDR_W'(PAGE_BYTES) + ADDR_W'(offset);
    endfunction

    // Presents one item from a falling edge and holds it until the block
    // takes it. Afterwards the sender may go quiet for a random stretch,
    // so that gaps land on every stage of the block's work.
    task automatic issue(bpa_func_t fn, int count, logic [ADDR_W-1:0] addr);
        @(negedge clk);
        start <= 1'b1;
        item  <= '{func: fn, page_count: COUNT_W'(count), address: addr};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 19))
                @(negedge clk);
        end
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Writes a register once no result is owed, then reads it back so the
    // checker can compare the returned value.
    task automatic set_register(bpa_reg_t r, logic [PDATA_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (r == REG_BASE)
            base_now = value[ADDR_W-1:0];
        else
            pool_now = value[POOL_W-1:0];
    endtask

    // Half allocates, mostly of a few pages so the bitmap fragments, and the
    // rest frees aimed inside the pool with a share aimed below or at random.
    function automatic bpa_in_t random_request();
        bpa_in_t req;
        int      pick;
        int      lim;
        req.page_count = COUNT_W'($urandom);
        req.address    = ADDR_W'({$urandom, $urandom});
        lim  = (pool_now > PAGES_DEF) ? PAGES_DEF : int'(pool_now);
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            req.func = FN_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                req.page_count = COUNT_W'($urandom_range(1, 4));
            else if (pick < 90)
                req.page_count = COUNT_W'($urandom_range(1, 16));
            else if (pick < 95)
                req.page_count = COUNT_W'($urandom_range(1, (lim > 0) ? lim : 1));
        end
        else
        begin
            req.func = FN_FREE;
            if (pick < 92)
                req.address = page_at($urandom_range(0, (lim > 0) ? lim - 1 : 7),
                                      $urandom_range(0, PAGE_BYTES - 1));
            else if (pick < 96)
                req.address = base_now - ADDR_W'($urandom_range(1, PAGE_BYTES));
        end
        return req;
    endfunction

    // A run of random requests with an occasional pause until the block
    // has answered everything outstanding.
    task automatic run_phase(int count, int pct);
        bpa_in_t req;
        gap_pct = pct;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 2)
                settle();
            req = random_request();
            issue(req.func, int'(req.page_count), req.address);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        item     = '0;
        gap_pct  = 35;
        base_now = BASE_RESET;
        pool_now = POOL_RESET;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on a full pool based at zero. The block clears its
        // bitmap after reset and holds busy meanwhile, which issue waits out.
        set_register(REG_BASE, '0);
        set_register(REG_POOL, PDATA_W'(1024));
        issue(FN_ALLOC, 0, '0);                     // zero-length run is refused
        issue(FN_ALLOC, 1, '0);                     // takes page 0
        issue(FN_ALLOC, 1024, '0);                  // page 0 is taken, no room
        issue(FN_FREE, 0, page_at(0, PAGE_BYTES - 1)); // offset within the page ignored
        issue(FN_FREE, 0, page_at(0, 0));           // freeing a free page is fine
        issue(FN_ALLOC, 1024, '0);                  // the whole pool at once
        issue(FN_ALLOC, 1, '0);
        issue(FN_ALLOC, 2047, '0);                  // longer than the pool
        issue(FN_FREE, 2047, page_at(1024, 0));     // just past the pool
        issue(FN_FREE, 0, '1);
        issue(FN_FREE, 0, page_at(5, 0));
        issue(FN_FREE, 0, page_at(6, 'h800));
        issue(FN_ALLOC, 3, '0);                     // only a hole of two pages
        issue(FN_ALLOC, 2, '1);                     // fills it exactly
        issue(FN_FREE, 0, page_at(1023, 0));        // last page of the pool
        issue(FN_ALLOC, 1, '0);
        issue(FN_FREE, 0, page_at(10, 'h123));

        // The base sits two pages below the top of the address space, so
        // page 10 wraps around. An oversized pool counts as the full one.
        set_register(REG_BASE, PDATA_W'(48'hFFFF_FFFF_E000));
        set_register(REG_POOL, PDATA_W'(2047));
        issue(FN_FREE, 0, page_at(1, 0));
        issue(FN_ALLOC, 1, '0);
        issue(FN_ALLOC, 1, '0);                     // page 10, address wraps
        issue(FN_FREE, 0, '0);                      // below the base

        // An empty pool refuses everything.
        set_register(REG_POOL, PDATA_W'(0));
        issue(FN_ALLOC, 1, '0);
        issue(FN_FREE, 0, page_at(0, 0));

        // A pool of one page.
        set_register(REG_BASE, PDATA_W'(48'h0000_8000_0000));
        set_register(REG_POOL, PDATA_W'(1));
        issue(FN_FREE, 0, page_at(0, 0));
        issue(FN_ALLOC, 2, '0);
        issue(FN_ALLOC, 1, '0);

        // Random part: the sender first pauses often, then more often, then
        // not at all, over a spread of pool sizes and bases.
        set_register(REG_BASE, '0);
        set_register(REG_POOL, PDATA_W'(1024));
        run_phase(300, 35);
        set_register(REG_BASE, PDATA_W'(48'h0000_1234_5000));
        set_register(REG_POOL, PDATA_W'(40));
        run_phase(300, 35);
        set_register(REG_BASE, PDATA_W'(48'hFFFF_FFFF_C000));
        set_register(REG_POOL, PDATA_W'(2047));
        run_phase(250, 65);
        set_register(REG_BASE, PDATA_W'(ADDR_W'({$urandom, $urandom})));
        set_register(REG_POOL, PDATA_W'(0));
        run_phase(30, 65);
        set_register(REG_BASE, PDATA_W'(48'hFFFF_FFFF_FFFF));
        set_register(REG_POOL, PDATA_W'(3));
        run_phase(60, 65);
        set_register(REG_BASE, PDATA_W'(ADDR_W'({$urandom, $urandom})));
        set_register(REG_POOL, PDATA_W'(200));
        run_phase(300, 0);
        set_register(REG_BASE, PDATA_W'(48'h8000_0000_0000));
        set_register(REG_POOL, PDATA_W'(1024));
        run_phase(200, 0);

        // Let every owed result arrive, then watch a little longer for
        // anything the block should not produce.
        settle();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("PASS bitmap_page_allocator_top");
        else
            $display("FAIL bitmap_page_allocator_top");
        $finish;
    end

endmodule

FILE: files.f
rtl/bpa_pkg.sv
rtl/bpa_regs.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator_top.sv
tb/page_map_checker.sv
tb/tb_bitmap_page_allocator_top.sv
